@@ sv/ibhq_pkg.sv @@
// Shared types and codes for the indexed binary heap queue.
package ibhq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_QUERY  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_RD,
    S_UPD_CMP,
    S_QRY,
    S_UP_RD,
    S_UP_CMP,
    S_RM_RD,
    S_RM_MV,
    S_TAKE,
    S_TAKE_LAST,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_FIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [7:0]         key;
    logic signed [31:0] priority_req;
  } request_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         top_key;
    logic signed [31:0] top_priority;
    logic [8:0]         count;
    logic               found;
    logic signed [31:0] found_priority;
  } result_t;

endpackage

@@ sv/ibhq_ram.sv @@
// Synchronous memory with one write port and one registered read port.
module ibhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A read of the entry being written returns the new word.
  always_ff @(posedge clk) begin
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/indexed_binary_heap_queue.sv @@
// Indexed binary heap queue: heap memory, key position memory and the sift sequencer.
// A push or update sift reads one parent per heap level, a sift down reads both children of a
// slot per level, and a remove climb reads one parent per level.
// The pace is set by the single read port of the heap memory, one slot read per cycle.
// busy is high from acceptance until the cycle that shows done; one command at a time.
// Synchronous reset empties the queue, marks every key absent and selects min ordering.
// The result is shown for one cycle with done; the receiver cannot stall it.
module indexed_binary_heap_queue #(
  parameter int CAPACITY      = 256,
  parameter int KEY_COUNT     = 256,
  parameter int PRIORITY_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ibhq_pkg::request_t request,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  output logic               done,
  output ibhq_pkg::result_t  result
);

  localparam int IW = $clog2(CAPACITY);
  localparam int KW = $clog2(KEY_COUNT);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = IW + 2;
  localparam int PW = PRIORITY_BITS;
  localparam int HW = KW + PW;

  ibhq_pkg::state_t state, state_next;
  ibhq_pkg::cmd_t   cmd;
  ibhq_pkg::status_t status;

  logic                 order_max;
  logic [CW-1:0]        count;
  logic [KEY_COUNT-1:0] present;
  logic [KW-1:0]        key_idx;
  logic                 kin;
  logic signed [PW-1:0] pri_in;
  logic                 found;
  logic signed [31:0]   fpri;
  logic [IW-1:0]        idx;
  logic [KW-1:0]        ent_key;
  logic signed [PW-1:0] ent_pri;
  logic [KW-1:0]        lent_key;
  logic signed [PW-1:0] lent_pri;

  logic          h_we;
  logic [IW-1:0] h_waddr, h_raddr;
  logic [HW-1:0] h_wdata, h_rdata;
  logic          p_we;
  logic [KW-1:0] p_waddr, p_raddr;
  logic [IW-1:0] p_wdata, p_rdata;

  logic [31:0]          key_ext;
  logic                 kin_in;
  logic [KW-1:0]        key_idx_in;
  logic signed [PW-1:0] pri_in_w;
  logic [KW-1:0]        h_key;
  logic signed [PW-1:0] h_pri;
  logic                 here;
  logic [CW-1:0]        cnt_m1;
  logic [IW-1:0]        par;
  logic [XW-1:0]        lch, rch, cnt_x;
  logic                 l_out, r_in, use_r, mv_better, up_better, upd_up;
  logic [KW-1:0]        mv_key;
  logic signed [PW-1:0] mv_pri;

  function automatic logic better(input logic signed [PW-1:0] a,
                                  input logic signed [PW-1:0] b,
                                  input logic om);
    better = om ? (a > b) : (a < b);
  endfunction

  ibhq_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  ibhq_ram #(.WIDTH(IW), .DEPTH(KEY_COUNT)) u_pos (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  assign key_ext    = 32'(request.key);
  assign kin_in     = key_ext < 32'(KEY_COUNT);
  assign key_idx_in = KW'(key_ext);
  assign pri_in_w   = PW'(64'(request.priority_req));

  assign h_key     = h_rdata[HW-1:PW];
  assign h_pri     = h_rdata[PW-1:0];
  assign here      = kin && present[key_idx];
  assign cnt_m1    = count - CW'(1);
  assign par       = IW'((idx - IW'(1)) >> 1);
  assign lch       = (XW'(idx) << 1) + XW'(1);
  assign rch       = lch + XW'(1);
  assign cnt_x     = XW'(count);
  assign l_out     = lch >= cnt_x;
  assign r_in      = rch < cnt_x;
  assign use_r     = r_in && better(h_pri, lent_pri, order_max);
  assign mv_key    = use_r ? h_key : lent_key;
  assign mv_pri    = use_r ? h_pri : lent_pri;
  assign mv_better = better(mv_pri, ent_pri, order_max);
  assign up_better = better(ent_pri, h_pri, order_max);
  assign upd_up    = better(pri_in, h_pri, order_max);

  always_comb begin
    state_next = state;
    case (state)
      ibhq_pkg::S_IDLE: begin
        if (start) state_next = ibhq_pkg::S_DISPATCH;
      end
      ibhq_pkg::S_DISPATCH: begin
        case (cmd)
          ibhq_pkg::CMD_PUSH: begin
            if (!kin || here || count == CW'(CAPACITY)) state_next = ibhq_pkg::S_FIN;
            else state_next = ibhq_pkg::S_UP_RD;
          end
          ibhq_pkg::CMD_POP: begin
            state_next = (count == '0) ? ibhq_pkg::S_FIN : ibhq_pkg::S_POP_RD;
          end
          ibhq_pkg::CMD_UPDATE: begin
            state_next = here ? ibhq_pkg::S_UPD_CMP : ibhq_pkg::S_FIN;
          end
          ibhq_pkg::CMD_REMOVE: begin
            state_next = here ? ibhq_pkg::S_RM_RD : ibhq_pkg::S_FIN;
          end
          ibhq_pkg::CMD_QUERY: begin
            state_next = here ? ibhq_pkg::S_QRY : ibhq_pkg::S_FIN;
          end
          default: state_next = ibhq_pkg::S_FIN;
        endcase
      end
      ibhq_pkg::S_POP_RD:    state_next = ibhq_pkg::S_TAKE;
      ibhq_pkg::S_UPD_CMP:   state_next = upd_up ? ibhq_pkg::S_UP_RD : ibhq_pkg::S_DN_RDL;
      ibhq_pkg::S_QRY:       state_next = ibhq_pkg::S_FIN;
      ibhq_pkg::S_UP_RD:     state_next = (idx == '0) ? ibhq_pkg::S_FIN : ibhq_pkg::S_UP_CMP;
      ibhq_pkg::S_UP_CMP:    state_next = up_better ? ibhq_pkg::S_UP_RD : ibhq_pkg::S_FIN;
      ibhq_pkg::S_RM_RD:     state_next = (idx == '0) ? ibhq_pkg::S_TAKE : ibhq_pkg::S_RM_MV;
      ibhq_pkg::S_RM_MV:     state_next = ibhq_pkg::S_RM_RD;
      ibhq_pkg::S_TAKE:
        state_next = (cnt_m1 == '0) ? ibhq_pkg::S_FIN : ibhq_pkg::S_TAKE_LAST;
      ibhq_pkg::S_TAKE_LAST: state_next = ibhq_pkg::S_DN_RDL;
      ibhq_pkg::S_DN_RDL:    state_next = l_out ? ibhq_pkg::S_FIN : ibhq_pkg::S_DN_RDR;
      ibhq_pkg::S_DN_RDR:    state_next = ibhq_pkg::S_DN_CMP;
      ibhq_pkg::S_DN_CMP:    state_next = mv_better ? ibhq_pkg::S_DN_RDL : ibhq_pkg::S_FIN;
      ibhq_pkg::S_FIN:       state_next = ibhq_pkg::S_OUT;
      ibhq_pkg::S_OUT:       state_next = ibhq_pkg::S_IDLE;
      default:               state_next = ibhq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    h_we    = 1'b0;
    h_waddr = idx;
    h_wdata = {ent_key, ent_pri};
    h_raddr = '0;
    p_we    = 1'b0;
    p_waddr = ent_key;
    p_wdata = idx;
    p_raddr = key_idx;
    case (state)
      ibhq_pkg::S_IDLE: p_raddr = key_idx_in;
      ibhq_pkg::S_DISPATCH: begin
        if (cmd == ibhq_pkg::CMD_UPDATE || cmd == ibhq_pkg::CMD_QUERY) h_raddr = p_rdata;
      end
      ibhq_pkg::S_UP_RD: begin
        if (idx == '0) begin
          h_we = 1'b1;
          p_we = 1'b1;
        end else begin
          h_raddr = par;
        end
      end
      ibhq_pkg::S_UP_CMP: begin
        h_we = 1'b1;
        p_we = 1'b1;
        if (up_better) begin
          h_wdata = h_rdata;
          p_waddr = h_key;
        end
      end
      ibhq_pkg::S_RM_RD: h_raddr = par;
      ibhq_pkg::S_RM_MV: begin
        h_we    = 1'b1;
        h_wdata = h_rdata;
        p_we    = 1'b1;
        p_waddr = h_key;
      end
      ibhq_pkg::S_TAKE: h_raddr = IW'(cnt_m1);
      ibhq_pkg::S_DN_RDL: begin
        if (l_out) begin
          h_we = 1'b1;
          p_we = 1'b1;
        end else begin
          h_raddr = IW'(lch);
        end
      end
      ibhq_pkg::S_DN_RDR: h_raddr = IW'(rch);
      ibhq_pkg::S_DN_CMP: begin
        h_we = 1'b1;
        p_we = 1'b1;
        if (mv_better) begin
          h_wdata = {mv_key, mv_pri};
          p_waddr = mv_key;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ibhq_pkg::S_IDLE;
      count     <= '0;
      present   <= '0;
      order_max <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) order_max <= cfg_wdata;
      case (state)
        ibhq_pkg::S_DISPATCH: begin
          if (cmd == ibhq_pkg::CMD_PUSH && kin && !here && count != CW'(CAPACITY)) begin
            count            <= count + CW'(1);
            present[key_idx] <= 1'b1;
          end
        end
        ibhq_pkg::S_TAKE: begin
          present[key_idx] <= 1'b0;
          count            <= cnt_m1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ibhq_pkg::S_IDLE: begin
        cmd     <= ibhq_pkg::cmd_t'(request.command);
        key_idx <= key_idx_in;
        kin     <= kin_in;
        pri_in  <= pri_in_w;
        status  <= ibhq_pkg::ST_OK;
        found   <= 1'b0;
        fpri    <= '0;
      end
      ibhq_pkg::S_DISPATCH: begin
        ent_key <= key_idx;
        ent_pri <= pri_in;
        idx     <= (cmd == ibhq_pkg::CMD_PUSH) ? IW'(count) : p_rdata;
        case (cmd)
          ibhq_pkg::CMD_PUSH: begin
            if (!kin) status <= ibhq_pkg::ST_ABSENT;
            else if (here) status <= ibhq_pkg::ST_PRESENT;
            else if (count == CW'(CAPACITY)) status <= ibhq_pkg::ST_FULL;
          end
          ibhq_pkg::CMD_POP: begin
            if (count == '0) status <= ibhq_pkg::ST_EMPTY;
          end
          ibhq_pkg::CMD_UPDATE, ibhq_pkg::CMD_REMOVE, ibhq_pkg::CMD_QUERY: begin
            if (!here) status <= ibhq_pkg::ST_ABSENT;
          end
          default: ;
        endcase
      end
      ibhq_pkg::S_POP_RD: begin
        key_idx <= h_key;
        idx     <= '0;
      end
      ibhq_pkg::S_QRY: begin
        found <= 1'b1;
        fpri  <= 32'(64'(h_pri));
      end
      ibhq_pkg::S_UP_CMP: begin
        if (up_better) idx <= par;
      end
      ibhq_pkg::S_RM_MV: idx <= par;
      ibhq_pkg::S_TAKE_LAST: begin
        ent_key <= h_key;
        ent_pri <= h_pri;
        idx     <= '0;
      end
      ibhq_pkg::S_DN_RDR: begin
        lent_key <= h_key;
        lent_pri <= h_pri;
      end
      ibhq_pkg::S_DN_CMP: begin
        if (mv_better) idx <= use_r ? IW'(rch) : IW'(lch);
      end
      default: ;
    endcase
  end

  assign busy = (state != ibhq_pkg::S_IDLE);
  assign done = (state == ibhq_pkg::S_OUT);

  always_comb begin
    result.status         = status;
    result.top_key        = (count != '0) ? 8'(h_key) : 8'd0;
    result.top_priority   = (count != '0) ? 32'(64'(h_pri)) : 32'sd0;
    result.count          = 9'(count);
    result.found          = found;
    result.found_priority = fpri;
  end

endmodule

@@ sv/ibhq_checker.sv @@
// Port-level checks for the indexed binary heap queue and their binding.
module ibhq_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input ibhq_pkg::result_t result
);

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("Result word shown for more than one cycle.");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("Accepted command did not raise busy.");

  a_done_release: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("Block still busy after its result word.");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
      done && result.count == 9'd0 |-> result.top_key == 8'd0 && result.top_priority == 32'sd0)
    else $error("Empty queue reported a best entry.");

endmodule

bind indexed_binary_heap_queue ibhq_checker u_ibhq_checker (.*);
